>>> hdl/vltsc_pkg.sv
// Package for the vehicle lamp and turn signal controller.
// Holds the shared item, result and configuration types and the fixed constants.
// No dependencies; every other file of the block but the checker uses it.
`timescale 1ns / 1ps

package vltsc_pkg;

    // Field widths fixed by the interface
    localparam int NOW_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MS_W       = 16;
    localparam int HAZ_W      = 4;

    // Configuration reset values
    localparam logic            IGNITION_RST    = 1'b1;
    localparam logic [MS_W-1:0] HALF_PERIOD_RST = 16'd500;
    localparam logic [MS_W-1:0] IDLE_TIMEOUT_RST = 16'd400;

    // Hazard counter thresholds and limits
    localparam int HAZ_RUN_MIN  = 4;
    localparam int HAZ_SYNC_MIN = 5;
    localparam int HAZ_MAX      = 15;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IGNITION     = 2'd0,
        REG_HALF_PERIOD  = 2'd1,
        REG_IDLE_TIMEOUT = 2'd2
    } cfg_reg_t;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic            ignition_on;
        logic [MS_W-1:0] blink_half_period_ms;
        logic [MS_W-1:0] blink_idle_timeout_ms;
    } cfg_t;

    // One polling pass
    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             highbeam_button_level;
        logic             mode_button_level;
        logic             main_light_level;
        logic             reverse_level;
        logic             rock_switch_level;
        logic             brake_level;
        logic             left_turn_level;
        logic             right_turn_level;
    } in_item_t;

    // Lamp drives for one pass
    typedef struct packed {
        logic light_mode_out;
        logic high_beam_on;
        logic low_beam_on;
        logic rock_lights_on;
        logic brake_lamp_on;
        logic front_left_lamp;
        logic rear_left_lamp;
        logic front_right_lamp;
        logic rear_right_lamp;
    } out_item_t;

endpackage

>>> hdl/vltsc_if.sv
// Handshake interfaces of the lamp controller: poll items, lamp results, config writes.
// Depends on vltsc_pkg for field widths.
`timescale 1ns / 1ps

interface vltsc_item_if;
    logic                         valid;
    logic                         ready;
    logic [vltsc_pkg::NOW_W-1:0]  now_ms;
    logic                         highbeam_button_level;
    logic                         mode_button_level;
    logic                         main_light_level;
    logic                         reverse_level;
    logic                         rock_switch_level;
    logic                         brake_level;
    logic                         left_turn_level;
    logic                         right_turn_level;

    modport source (
        output valid, now_ms, highbeam_button_level, mode_button_level, main_light_level,
               reverse_level, rock_switch_level, brake_level, left_turn_level,
               right_turn_level,
        input  ready
    );
    modport sink (
        input  valid, now_ms, highbeam_button_level, mode_button_level, main_light_level,
               reverse_level, rock_switch_level, brake_level, left_turn_level,
               right_turn_level,
        output ready
    );
endinterface

interface vltsc_result_if;
    logic valid;
    logic ready;
    logic light_mode_out;
    logic high_beam_on;
    logic low_beam_on;
    logic rock_lights_on;
    logic brake_lamp_on;
    logic front_left_lamp;
    logic rear_left_lamp;
    logic front_right_lamp;
    logic rear_right_lamp;

    modport source (
        output valid, light_mode_out, high_beam_on, low_beam_on, rock_lights_on,
               brake_lamp_on, front_left_lamp, rear_left_lamp, front_right_lamp,
               rear_right_lamp,
        input  ready
    );
    modport sink (
        input  valid, light_mode_out, high_beam_on, low_beam_on, rock_lights_on,
               brake_lamp_on, front_left_lamp, rear_left_lamp, front_right_lamp,
               rear_right_lamp,
        output ready
    );
endinterface

interface vltsc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vltsc_pkg::CFG_IDX_W-1:0]   index;
    logic [vltsc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/vltsc_cfg_regs.sv
// Configuration register file of the lamp controller.
// Depends on vltsc_pkg and the vltsc_cfg_if interface.
`timescale 1ns / 1ps

module vltsc_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    vltsc_cfg_if.sink         cfg,
    output vltsc_pkg::cfg_t   cfg_val
);

    logic                             ignition_reg;
    logic [vltsc_pkg::MS_W-1:0]       half_reg;
    logic [vltsc_pkg::MS_W-1:0]       idle_reg;
    vltsc_pkg::cfg_reg_t              wr_index;

    // Writes are always taken; an unknown index is dropped.
    assign cfg.ready = 1'b1;
    assign wr_index  = vltsc_pkg::cfg_reg_t'(cfg.index);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignition_reg <= vltsc_pkg::IGNITION_RST;
            half_reg     <= vltsc_pkg::HALF_PERIOD_RST;
            idle_reg     <= vltsc_pkg::IDLE_TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (wr_index)
                vltsc_pkg::REG_IGNITION:     ignition_reg <= cfg.data[0];
                vltsc_pkg::REG_HALF_PERIOD:  half_reg     <= cfg.data[vltsc_pkg::MS_W-1:0];
                vltsc_pkg::REG_IDLE_TIMEOUT: idle_reg     <= cfg.data[vltsc_pkg::MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_val.ignition_on           = ignition_reg;
    assign cfg_val.blink_half_period_ms  = half_reg;
    assign cfg_val.blink_idle_timeout_ms = idle_reg;

endmodule

>>> hdl/vltsc_core.sv
// Per-poll state update of the lamp controller: button toggles, blinkers, hazard count.
// Depends on vltsc_pkg. The result is combinational from the current state and item.
`timescale 1ns / 1ps

module vltsc_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  vltsc_pkg::in_item_t    item,
    input  vltsc_pkg::cfg_t        cfg_val,
    output vltsc_pkg::out_item_t   result
);

    // State
    logic                          hb_prev_reg, hb_prev_next;
    logic                          mode_prev_reg, mode_prev_next;
    logic                          light_mode_reg, light_mode_next;
    logic                          high_beam_reg, high_beam_next;
    logic [1:0]                    turn_prev_reg, turn_prev_next;
    logic [1:0]                    phase_reg, phase_next;
    logic [TIME_BITS-1:0]          timer_reg, timer_next;
    logic [vltsc_pkg::HAZ_W-1:0]   haz_reg, haz_next;

    logic [TIME_BITS-1:0]          now_t;
    logic [TIME_BITS-1:0]          elapsed;
    logic                          half_passed;
    logic                          idle_passed;
    logic [1:0]                    sw;
    logic                          reverse_req;

    // Poll time folded to the timer width
    generate
        if (TIME_BITS <= vltsc_pkg::NOW_W)
        begin : g_now_trunc
            assign now_t = item.now_ms[TIME_BITS-1:0];
        end
        else
        begin : g_now_ext
            assign now_t = TIME_BITS'(item.now_ms);
        end
    endgenerate

    // One subtractor; a timer reload within the pass makes later differences zero.
    assign elapsed     = now_t - timer_reg;
    assign half_passed = elapsed > TIME_BITS'(cfg_val.blink_half_period_ms);
    assign idle_passed = elapsed > TIME_BITS'(cfg_val.blink_idle_timeout_ms);
    assign sw          = ~{item.right_turn_level, item.left_turn_level};
    assign reverse_req = ~item.reverse_level | ~item.rock_switch_level;

    // Next state, left side first and then right side
    always_comb
    begin
        logic              hb_toggled;
        logic signed [5:0] haz;
        logic              timer_load;
        logic              elapsed_ok;

        hb_toggled      = high_beam_reg ^ (~item.highbeam_button_level & hb_prev_reg);
        light_mode_next = light_mode_reg ^ (~item.mode_button_level & mode_prev_reg);
        high_beam_next  = hb_toggled & light_mode_next & item.main_light_level;
        hb_prev_next    = item.highbeam_button_level;
        mode_prev_next  = item.mode_button_level;

        haz            = signed'({2'b00, haz_reg});
        phase_next     = phase_reg;
        turn_prev_next = turn_prev_reg;
        timer_load     = 1'b0;
        elapsed_ok     = half_passed;

        for (int i = 0; i < 2; i++)
        begin
            // Blink step on a running side
            if ((sw[i] || haz > vltsc_pkg::HAZ_RUN_MIN) && elapsed_ok)
            begin
                phase_next[i] = ~phase_next[i];
                haz           = haz - 6'sd1;
                if (haz > vltsc_pkg::HAZ_SYNC_MIN)
                begin
                    phase_next[1] = phase_next[0];
                    haz           = haz + 6'sd1;
                end
                timer_load = 1'b1;
                elapsed_ok = 1'b0;
            end
            // Switch change restarts the side
            if (sw[i] != turn_prev_next[i])
            begin
                haz               = haz + 6'sd1;
                turn_prev_next[i] = sw[i];
                phase_next[i]     = sw[i];
                timer_load        = 1'b1;
                elapsed_ok        = 1'b0;
            end
        end

        // Clamp the hazard count
        if (haz < 6'sd0)
        begin
            haz_next = '0;
        end
        else if (haz > vltsc_pkg::HAZ_MAX)
        begin
            haz_next = vltsc_pkg::HAZ_W'(vltsc_pkg::HAZ_MAX);
        end
        else
        begin
            haz_next = haz[vltsc_pkg::HAZ_W-1:0];
        end

        // Idle timeout with both switches off
        if (!timer_load && idle_passed && (sw == 2'b00))
        begin
            haz_next   = '0;
            phase_next = 2'b00;
        end

        timer_next = timer_load ? now_t : timer_reg;
    end

    // Lamp drives from the updated state
    always_comb
    begin
        result.light_mode_out   = light_mode_next;
        result.high_beam_on     = high_beam_next & cfg_val.ignition_on;
        result.low_beam_on      = item.main_light_level ^ high_beam_next;
        result.rock_lights_on   = ~item.rock_switch_level & light_mode_next;
        result.brake_lamp_on    = ~item.brake_level;
        result.front_left_lamp  = phase_next[0] ^ light_mode_next;
        result.rear_left_lamp   = phase_next[0] ^ reverse_req;
        result.front_right_lamp = phase_next[1] ^ light_mode_next;
        result.rear_right_lamp  = phase_next[1] ^ reverse_req;
    end

    // State registers advance once per processed poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_prev_reg    <= 1'b1;
            mode_prev_reg  <= 1'b0;
            light_mode_reg <= 1'b1;
            high_beam_reg  <= 1'b0;
            turn_prev_reg  <= 2'b00;
            phase_reg      <= 2'b00;
            timer_reg      <= '0;
            haz_reg        <= '0;
        end
        else if (step)
        begin
            hb_prev_reg    <= hb_prev_next;
            mode_prev_reg  <= mode_prev_next;
            light_mode_reg <= light_mode_next;
            high_beam_reg  <= high_beam_next;
            turn_prev_reg  <= turn_prev_next;
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            haz_reg        <= haz_next;
        end
    end

endmodule

>>> hdl/vehicle_lamp_and_turn_signal_control_top.sv
// Top level of the vehicle lamp and turn signal controller.
// Depends on vltsc_pkg, the interfaces in vltsc_if, vltsc_cfg_regs and vltsc_core.
//
//   Channel     Direction  Carries
//   item_in     sink       one poll: time stamp and raw switch levels
//   result_out  source     lamp drives for that poll
//   cfg         sink       register index and write data
//
// One poll is taken per cycle unless a full result register stalls. A poll is held in
// the input register, is evaluated against the controller state and lands in the
// result register, from which its lamp drives are taken.
// The result register parts the two sides: a full result register that is being
// taken does not stall input.
// Reset clears both valid flags, the state and the configuration; no clearing pass.
`timescale 1ns / 1ps

module vehicle_lamp_and_turn_signal_control_top #(
    parameter int TIME_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    vltsc_item_if.sink       item_in,
    vltsc_result_if.source   result_out,
    vltsc_cfg_if.sink        cfg
);

    logic                    in_vld_reg;
    vltsc_pkg::in_item_t     in_item_reg;
    logic                    out_vld_reg;
    vltsc_pkg::out_item_t    out_item_reg;
    vltsc_pkg::in_item_t     in_item;
    vltsc_pkg::out_item_t    core_result;
    vltsc_pkg::cfg_t         cfg_val;
    logic                    out_free;
    logic                    advance;

    // Configuration registers
    vltsc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    // Gather the request fields
    assign in_item.now_ms                = item_in.now_ms;
    assign in_item.highbeam_button_level = item_in.highbeam_button_level;
    assign in_item.mode_button_level     = item_in.mode_button_level;
    assign in_item.main_light_level      = item_in.main_light_level;
    assign in_item.reverse_level         = item_in.reverse_level;
    assign in_item.rock_switch_level     = item_in.rock_switch_level;
    assign in_item.brake_level           = item_in.brake_level;
    assign in_item.left_turn_level       = item_in.left_turn_level;
    assign in_item.right_turn_level      = item_in.right_turn_level;

    // Flow control between the input and result registers
    assign out_free      = !out_vld_reg || result_out.ready;
    assign advance       = in_vld_reg && out_free;
    assign item_in.ready = !in_vld_reg || out_free;

    // Controller state and per-poll logic
    vltsc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (in_item_reg),
        .cfg_val (cfg_val),
        .result  (core_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_vld_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            in_item_reg <= in_item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    // Drive the result channel
    assign result_out.valid            = out_vld_reg;
    assign result_out.light_mode_out   = out_item_reg.light_mode_out;
    assign result_out.high_beam_on     = out_item_reg.high_beam_on;
    assign result_out.low_beam_on      = out_item_reg.low_beam_on;
    assign result_out.rock_lights_on   = out_item_reg.rock_lights_on;
    assign result_out.brake_lamp_on    = out_item_reg.brake_lamp_on;
    assign result_out.front_left_lamp  = out_item_reg.front_left_lamp;
    assign result_out.rear_left_lamp   = out_item_reg.rear_left_lamp;
    assign result_out.front_right_lamp = out_item_reg.front_right_lamp;
    assign result_out.rear_right_lamp  = out_item_reg.rear_right_lamp;

endmodule

>>> hdl/vltsc_checker.sv
// Port-level checker for the lamp controller and its bind to the top level.
// Depends only on the top level's ports; no package needed.
`timescale 1ns / 1ps

module vltsc_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic light_mode_out,
    input logic high_beam_on,
    input logic low_beam_on,
    input logic front_left_lamp,
    input logic rear_left_lamp,
    input logic front_right_lamp,
    input logic rear_right_lamp
);

    // No result is shown right after reset is released.
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result valid directly after reset");

    // The high beam is forced off whenever the light mode is off.
    a_hb_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && high_beam_on |-> light_mode_out)
        else $error("high beam on with light mode off");

    // A high beam needs the main light on, which turns the low beam off.
    a_hb_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && high_beam_on |-> !low_beam_on)
        else $error("high and low beam both on");

    // Front and rear lamps carry the same blinker phases on each side.
    a_phase_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((front_left_lamp ^ front_right_lamp) ==
                       (rear_left_lamp ^ rear_right_lamp)))
        else $error("front and rear blinker phases disagree");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(light_mode_out) &&
        $stable(high_beam_on) && $stable(front_left_lamp) && $stable(rear_right_lamp))
        else $error("stalled result changed");

endmodule

bind vehicle_lamp_and_turn_signal_control_top vltsc_checker u_vltsc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (result_out.valid),
    .out_ready        (result_out.ready),
    .light_mode_out   (result_out.light_mode_out),
    .high_beam_on     (result_out.high_beam_on),
    .low_beam_on      (result_out.low_beam_on),
    .front_left_lamp  (result_out.front_left_lamp),
    .rear_left_lamp   (result_out.rear_left_lamp),
    .front_right_lamp (result_out.front_right_lamp),
    .rear_right_lamp  (result_out.rear_right_lamp)
);

>>> bench/vehicle_lamp_and_turn_signal_control_top_tb.sv
// Self-checking testbench for the vehicle lamp and turn signal controller.
// Drives poll requests and register writes, predicts every lamp result and compares.
// Depends on vltsc_pkg, the vltsc_if interfaces and vehicle_lamp_and_turn_signal_control_top.
`timescale 1ns / 1ps

module vehicle_lamp_and_turn_signal_control_top_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int RX_HOLD_LEN = 80;
    localparam logic [vltsc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    // Switch levels, MSB first: highbeam, mode, main, reverse, rock, brake, left, right.
    localparam logic [7:0] ALL_RELEASED = 8'b1111_1111;

    typedef enum int {
        TURN_IDLE,
        TURN_LEFT,
        TURN_RIGHT,
        TURN_FLICK,
        TURN_NOISE
    } turn_style_t;

    logic clk;
    logic rst_n;

    vltsc_item_if   poll_ch ();
    vltsc_result_if lamp_ch ();
    vltsc_cfg_if    reg_ch ();

    vehicle_lamp_and_turn_signal_control_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (poll_ch),
        .result_out (lamp_ch),
        .cfg        (reg_ch)
    );

    // Pending polls and the lamp drives expected for accepted ones.
    vltsc_pkg::in_item_t  poll_q [$];
    vltsc_pkg::out_item_t lamp_q [$];

    // Controller state as the checker sees it.
    vltsc_pkg::cfg_t reg_mirror;
    logic        hb_prev_q;
    logic        mode_prev_q;
    logic        light_mode_q;
    logic        high_beam_q;
    logic [1:0]  turn_prev_q;
    logic [1:0]  blink_phase_q;
    logic [31:0] blink_start_q;
    logic [3:0]  hazard_q;

    // Bookkeeping.
    int  polls_pushed;
    int  polls_accepted;
    int  results_checked;
    int  mismatch_count;
    int  settings_used;
    bit  poll_taken;
    int  quiet_cycles;

    // Sender and receiver pacing.
    int         tx_burst;
    int         tx_gap;
    int         tx_gap_max;
    int         rx_hold_asks;
    int         rx_hold_done;
    int         rx_hold_left;
    int         rx_tick;
    bit         rx_stall_on;
    logic [7:0] rx_pattern;

    // Stimulus generator state.
    logic [31:0] gen_now;
    logic        hb_lvl;
    logic        mode_lvl;
    logic        main_lvl;
    turn_style_t turn_style;
    int          turn_run;
    int          flick_side;

    string lamp_field [9] = '{"light_mode_out", "high_beam_on", "low_beam_on",
                              "rock_lights_on", "brake_lamp_on", "front_left_lamp",
                              "rear_left_lamp", "front_right_lamp", "rear_right_lamp"};

    // Clock, 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Advance the controller state by one poll and return its lamp drives.
    function automatic vltsc_pkg::out_item_t lamp_predict(input vltsc_pkg::in_item_t p);
        vltsc_pkg::out_item_t o;
        logic [1:0]  turn_on;
        logic        rev_req;
        logic        s;
        logic [31:0] elapsed;
        int          haz;
        int          side;

        turn_on = {~p.right_turn_level, ~p.left_turn_level};
        haz = hazard_q;

        // Both buttons toggle on the press edge; high beam needs main light and mode.
        if (!p.highbeam_button_level && hb_prev_q)
            high_beam_q = ~high_beam_q;
        hb_prev_q = p.highbeam_button_level;
        if (!p.mode_button_level && mode_prev_q)
            light_mode_q = ~light_mode_q;
        mode_prev_q = p.mode_button_level;
        if (!light_mode_q || !p.main_light_level)
            high_beam_q = 1'b0;

        rev_req = ~p.reverse_level | ~p.rock_switch_level;

        // Left side first, then right.
        for (side = 0; side < 2; side++)
        begin
            s = turn_on[side];
            if (s || haz > vltsc_pkg::HAZ_RUN_MIN)
            begin
                elapsed = p.now_ms - blink_start_q;
                if (elapsed > 32'(reg_mirror.blink_half_period_ms))
                begin
                    blink_phase_q[side] = ~blink_phase_q[side];
                    haz--;
                    // A well-armed hazard keeps both sides in step.
                    if (haz > vltsc_pkg::HAZ_SYNC_MIN)
                    begin
                        blink_phase_q[1] = blink_phase_q[0];
                        haz++;
                    end
                    blink_start_q = p.now_ms;
                end
            end
            if (s != turn_prev_q[side])
            begin
                haz++;
                turn_prev_q[side] = s;
                blink_phase_q[side] = s;
                blink_start_q = p.now_ms;
            end
        end

        if (haz < 0)
            haz = 0;
        if (haz > vltsc_pkg::HAZ_MAX)
            haz = vltsc_pkg::HAZ_MAX;

        // Switches off long enough: blinkers and hazard clear.
        elapsed = p.now_ms - blink_start_q;
        if (elapsed > 32'(reg_mirror.blink_idle_timeout_ms) && turn_on == 2'b00)
        begin
            haz = 0;
            blink_phase_q = 2'b00;
        end
        hazard_q = haz[3:0];

        o.light_mode_out   = light_mode_q;
        o.high_beam_on     = high_beam_q & reg_mirror.ignition_on;
        o.low_beam_on      = p.main_light_level ^ high_beam_q;
        o.rock_lights_on   = ~p.rock_switch_level & light_mode_q;
        o.brake_lamp_on    = ~p.brake_level;
        o.front_left_lamp  = blink_phase_q[0] ^ light_mode_q;
        o.rear_left_lamp   = blink_phase_q[0] ^ rev_req;
        o.front_right_lamp = blink_phase_q[1] ^ light_mode_q;
        o.rear_right_lamp  = blink_phase_q[1] ^ rev_req;
        return o;
    endfunction

    task automatic add_poll(input logic [31:0] t, input logic [7:0] levels);
        poll_q.push_back(vltsc_pkg::in_item_t'({t, levels}));
        polls_pushed++;
    endtask

    // Random polls: time mostly moves forward, turn switches follow short patterns.
    task automatic add_random_polls(input int count, input int step_max);
        vltsc_pkg::in_item_t p;
        int       pick;
        int       n;

        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 86)
                gen_now = gen_now + 32'($urandom_range(0, step_max));
            else if (pick < 93)
                gen_now = gen_now - 32'($urandom_range(0, step_max));
            else
                gen_now = $urandom();

            if (turn_run == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    turn_style = TURN_IDLE;
                else if (pick < 5)
                    turn_style = TURN_LEFT;
                else if (pick < 6)
                    turn_style = TURN_RIGHT;
                else if (pick < 9)
                    turn_style = TURN_FLICK;
                else
                    turn_style = TURN_NOISE;
                turn_run = $urandom_range(3, 16);
                flick_side = $urandom_range(0, 1);
            end
            turn_run--;

            p = poll_q.size() != 0 ? poll_q[$] :
                vltsc_pkg::in_item_t'({gen_now, ALL_RELEASED});
            case (turn_style)
                TURN_IDLE:
                begin
                    p.left_turn_level  = 1'b1;
                    p.right_turn_level = 1'b1;
                end
                TURN_LEFT:
                begin
                    p.left_turn_level  = 1'b0;
                    p.right_turn_level = 1'b1;
                end
                TURN_RIGHT:
                begin
                    p.left_turn_level  = 1'b1;
                    p.right_turn_level = 1'b0;
                end
                TURN_FLICK:
                begin
                    // Rapid toggling of one switch arms the hazard counter.
                    if (flick_side == 0)
                        p.left_turn_level = ~p.left_turn_level;
                    else
                        p.right_turn_level = ~p.right_turn_level;
                end
                default:
                begin
                    p.left_turn_level  = 1'($urandom_range(0, 1));
                    p.right_turn_level = 1'($urandom_range(0, 1));
                end
            endcase

            if ($urandom_range(0, 3) == 0)
                hb_lvl = ~hb_lvl;
            if ($urandom_range(0, 3) == 0)
                mode_lvl = ~mode_lvl;
            if ($urandom_range(0, 7) == 0)
                main_lvl = ~main_lvl;

            p.now_ms                = gen_now;
            p.highbeam_button_level = hb_lvl;
            p.mode_button_level     = mode_lvl;
            p.main_light_level      = main_lvl;
            p.reverse_level         = $urandom_range(0, 3) != 0;
            p.rock_switch_level     = $urandom_range(0, 2) != 0;
            p.brake_level           = 1'($urandom_range(0, 1));
            poll_q.push_back(p);
            polls_pushed++;
        end
    endtask

    // Register write over the configuration channel.
    task automatic write_reg(input logic [vltsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vltsc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= val;
        do
            @(posedge clk);
        while (!reg_ch.ready);
        @(negedge clk);
        reg_ch.valid <= 1'b0;
    endtask

    // Wait until every pushed poll has been accepted and answered.
    task automatic settle();
        do
            @(negedge clk);
        while (polls_accepted != polls_pushed || lamp_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Poll sender: bursts of requests separated by random gaps.
    always @(negedge clk)
    begin : poll_driver
        vltsc_pkg::in_item_t nxt;
        if (!rst_n)
            poll_ch.valid <= 1'b0;
        else if (!poll_ch.valid || poll_taken)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                poll_ch.valid <= 1'b0;
            end
            else if (poll_q.size() != 0)
            begin
                nxt = poll_q.pop_front();
                poll_ch.valid                 <= 1'b1;
                poll_ch.now_ms                <= nxt.now_ms;
                poll_ch.highbeam_button_level <= nxt.highbeam_button_level;
                poll_ch.mode_button_level     <= nxt.mode_button_level;
                poll_ch.main_light_level      <= nxt.main_light_level;
                poll_ch.reverse_level         <= nxt.reverse_level;
                poll_ch.rock_switch_level     <= nxt.rock_switch_level;
                poll_ch.brake_level           <= nxt.brake_level;
                poll_ch.left_turn_level       <= nxt.left_turn_level;
                poll_ch.right_turn_level      <= nxt.right_turn_level;
                if (tx_burst > 1)
                    tx_burst--;
                else
                begin
                    tx_burst = $urandom_range(1, 24);
                    tx_gap = tx_gap_max == 0 ? 0 : $urandom_range(0, tx_gap_max);
                end
            end
            else
                poll_ch.valid <= 1'b0;
        end
    end

    // Result receiver: rotating stall pattern, plus long hold-offs on request.
    always @(negedge clk)
    begin : lamp_sink
        if (!rst_n)
            lamp_ch.ready <= 1'b0;
        else
        begin
            if (rx_hold_done != rx_hold_asks)
            begin
                rx_hold_done++;
                rx_hold_left = RX_HOLD_LEN;
            end
            if (rx_tick == 0)
            begin
                rx_tick = 48;
                if (!rx_stall_on || $urandom_range(0, 3) == 0)
                    rx_pattern = 8'hFF;
                else
                    rx_pattern = 8'($urandom()) | 8'h01;
            end
            rx_tick--;
            rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                lamp_ch.ready <= 1'b0;
            end
            else
                lamp_ch.ready <= rx_pattern[0];
        end
    end

    // Monitor: predict on poll acceptance, mirror register writes, check results.
    always @(posedge clk)
    begin : lamp_monitor
        vltsc_pkg::in_item_t  seen;
        vltsc_pkg::out_item_t got;
        vltsc_pkg::out_item_t want;
        int        k;
        if (rst_n)
        begin
            poll_taken = poll_ch.valid && poll_ch.ready;
            if (poll_taken)
            begin
                seen = {poll_ch.now_ms, poll_ch.highbeam_button_level,
                        poll_ch.mode_button_level, poll_ch.main_light_level,
                        poll_ch.reverse_level, poll_ch.rock_switch_level,
                        poll_ch.brake_level, poll_ch.left_turn_level,
                        poll_ch.right_turn_level};
                lamp_q.push_back(lamp_predict(seen));
                polls_accepted++;
            end

            if (reg_ch.valid && reg_ch.ready)
            begin
                case (reg_ch.index)
                    vltsc_pkg::REG_IGNITION:
                        reg_mirror.ignition_on = reg_ch.data[0];
                    vltsc_pkg::REG_HALF_PERIOD:
                        reg_mirror.blink_half_period_ms = reg_ch.data;
                    vltsc_pkg::REG_IDLE_TIMEOUT:
                        reg_mirror.blink_idle_timeout_ms = reg_ch.data;
                    default:          ; // Unmapped index: the write has no effect.
                endcase
            end

            if (lamp_ch.valid && lamp_ch.ready)
            begin
                got = {lamp_ch.light_mode_out, lamp_ch.high_beam_on, lamp_ch.low_beam_on,
                       lamp_ch.rock_lights_on, lamp_ch.brake_lamp_on, lamp_ch.front_left_lamp,
                       lamp_ch.rear_left_lamp, lamp_ch.front_right_lamp,
                       lamp_ch.rear_right_lamp};
                if (lamp_q.size() == 0)
                    report_mismatch("lamp result with no poll outstanding");
                else
                begin
                    want = lamp_q.pop_front();
                    results_checked++;
                    for (k = 0; k < 9; k++)
                    begin
                        if (got[8-k] !== want[8-k])
                            report_mismatch($sformatf("result %0d %s: got %b, expected %b",
                                results_checked, lamp_field[k], got[8-k], want[8-k]));
                    end
                end
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((poll_ch.valid && poll_ch.ready) || (lamp_ch.valid && lamp_ch.ready) ||
                (reg_ch.valid && reg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, lamp_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin : run_control
        int half;

        // Known values on every input before reset is released.
        poll_ch.valid                 = 1'b0;
        poll_ch.now_ms                = '0;
        poll_ch.highbeam_button_level = 1'b1;
        poll_ch.mode_button_level     = 1'b1;
        poll_ch.main_light_level      = 1'b1;
        poll_ch.reverse_level         = 1'b1;
        poll_ch.rock_switch_level     = 1'b1;
        poll_ch.brake_level           = 1'b1;
        poll_ch.left_turn_level       = 1'b1;
        poll_ch.right_turn_level      = 1'b1;
        lamp_ch.ready                 = 1'b0;
        reg_ch.valid                  = 1'b0;
        reg_ch.index                  = '0;
        reg_ch.data                   = '0;

        reg_mirror.ignition_on           = vltsc_pkg::IGNITION_RST;
        reg_mirror.blink_half_period_ms  = vltsc_pkg::HALF_PERIOD_RST;
        reg_mirror.blink_idle_timeout_ms = vltsc_pkg::IDLE_TIMEOUT_RST;
        hb_prev_q     = 1'b1;
        mode_prev_q   = 1'b0;
        light_mode_q  = 1'b1;
        high_beam_q   = 1'b0;
        turn_prev_q   = 2'b00;
        blink_phase_q = 2'b00;
        blink_start_q = '0;
        hazard_q      = '0;

        tx_burst    = 1;
        tx_gap      = 0;
        tx_gap_max  = 6;
        rx_stall_on = 1'b1;
        rx_pattern  = 8'hFF;
        gen_now     = '0;
        hb_lvl      = 1'b1;
        mode_lvl    = 1'b1;
        main_lvl    = 1'b1;
        turn_style  = TURN_IDLE;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: button edges, lamp mixing, blink timing, hazard, time wrap.
        settings_used++;
        add_poll(32'd0,    ALL_RELEASED);
        add_poll(32'd5,    8'b0111_1111);
        add_poll(32'd6,    ALL_RELEASED);
        add_poll(32'd7,    8'b0111_1111);
        add_poll(32'd8,    ALL_RELEASED);
        add_poll(32'd9,    8'b0111_1111);
        add_poll(32'd10,   8'b1101_1111);
        add_poll(32'd11,   8'b1011_1111);
        add_poll(32'd12,   8'b0111_1111);
        add_poll(32'd13,   8'b1011_1111);
        add_poll(32'd14,   8'b1110_0011);
        add_poll(32'd20,   8'b1111_1101);
        add_poll(32'd521,  8'b1111_1101);
        add_poll(32'd1021, 8'b1111_1101);
        add_poll(32'd1022, 8'b1111_1101);
        add_poll(32'd1030, 8'b1111_1110);
        add_poll(32'd1031, ALL_RELEASED);
        add_poll(32'd1032, 8'b1111_1101);
        add_poll(32'd1033, ALL_RELEASED);
        add_poll(32'd1034, 8'b1111_1101);
        add_poll(32'd1035, ALL_RELEASED);
        add_poll(32'd1600, ALL_RELEASED);
        add_poll(32'd0,    ALL_RELEASED);
        add_poll(32'hFFFF_FFFF, 8'b0000_0000);
        add_poll(32'h0000_0010, ALL_RELEASED);
        gen_now = 32'h0000_0010;
        add_random_polls(100, 400);
        settle();
        add_random_polls(100, 700);
        settle();

        // One-millisecond periods, ignition off through its bit 0, no idling on either side.
        write_reg(vltsc_pkg::REG_IGNITION, 16'hFFFE);
        write_reg(vltsc_pkg::REG_HALF_PERIOD, 16'd1);
        write_reg(vltsc_pkg::REG_IDLE_TIMEOUT, 16'd1);
        settings_used++;
        tx_gap_max  = 0;
        rx_stall_on = 1'b0;
        add_random_polls(150, 4);
        settle();

        // Longest periods with large time steps.
        write_reg(vltsc_pkg::REG_IGNITION, 16'h0001);
        write_reg(vltsc_pkg::REG_HALF_PERIOD, 16'hFFFF);
        write_reg(vltsc_pkg::REG_IDLE_TIMEOUT, 16'hFFFF);
        settings_used++;
        tx_gap_max  = 12;
        rx_stall_on = 1'b1;
        add_random_polls(150, 140000);
        settle();

        // Zero periods; a write to the unmapped index must change nothing.
        write_reg(vltsc_pkg::REG_IGNITION, 16'h0000);
        write_reg(vltsc_pkg::REG_HALF_PERIOD, 16'd0);
        write_reg(vltsc_pkg::REG_IDLE_TIMEOUT, 16'd0);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        settings_used++;
        tx_gap_max = 3;
        add_random_polls(100, 2);
        settle();

        // Idle timeout above the half period so the hazard keeps running; receiver backs up.
        half = $urandom_range(50, 300);
        write_reg(vltsc_pkg::REG_IGNITION, 16'h0001);
        write_reg(vltsc_pkg::REG_HALF_PERIOD, 16'(half));
        write_reg(vltsc_pkg::REG_IDLE_TIMEOUT, 16'(half + $urandom_range(100, 400)));
        settings_used++;
        tx_gap_max = 5;
        add_random_polls(200, half + half / 2);
        rx_hold_asks++;
        settle();

        repeat (6) @(posedge clk);
        if (lamp_q.size() != 0)
            report_mismatch($sformatf("%0d lamp results never arrived", lamp_q.size()));

        $display("Checked %0d lamp results for %0d polls over %0d register settings,",
                 results_checked, polls_accepted, settings_used);
        $display("from zero to full-scale blink periods, with %0d mismatches.", mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
